// ===== hw/rtl/i2c_master_bit_sequencer_defines.svh =====
// assertion macros for the i2c bit sequencer
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// checked only out of reset
`define I2CS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define I2CS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cs_pkg.sv =====
// types, codes and phase decode for the i2c bit sequencer
`default_nettype none

package i2cs_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic [4:0] LEN_START = 5'd4;
  localparam logic [4:0] LEN_STOP  = 5'd3;
  localparam logic [4:0] LEN_BYTE  = 5'd28;

  // fixed phases outside the bit loop
  localparam logic [4:0] PH_ACK_SDA  = 5'd24;
  localparam logic [4:0] PH_ACK_SCL  = 5'd25;
  localparam logic [4:0] PH_ACK_SMP  = 5'd26;
  localparam logic [4:0] PH_RACK_SDA = 5'd25;
  localparam logic [4:0] PH_RACK_SCL = 5'd26;

  // sub-phase codes within one bit slot
  localparam logic [1:0] SUB_SETUP = 2'd0;
  localparam logic [1:0] SUB_HIGH  = 2'd1;
  localparam logic [1:0] SUB_LOW   = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_data;
    logic       ack_to_send;
    logic       sda_in;
  } in_beat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_seen;
    logic       rejected;
  } out_beat_t;

  typedef struct packed {
    logic [2:0] bit_idx;
    logic [1:0] sub;
  } phase_split_t;

  // q / 3 and q % 3 for q below 24: (q * 11) >> 5 is exact there
  function automatic phase_split_t phase_split(input logic [4:0] q);
    logic [8:0]   prod;
    logic [4:0]   three_b;
    logic [4:0]   rem;
    phase_split_t r;
    prod        = {4'b0000, q} * 9'd11;
    r.bit_idx   = prod[7:5];
    three_b     = {1'b0, r.bit_idx, 1'b0} + {2'b00, r.bit_idx};
    rem         = q - three_b;
    r.sub       = rem[1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// i2c master bit sequencer: one line phase per input beat, open-drain drive levels out
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready holds, set by the single register stage from line state to result
// in_ready stays high while the result register is empty or being drained this cycle
// reset (synchronous, rst_n low): idle, phase 0, both lines released, result register empty
// a start takes 4 beats, a stop 3, a byte write or read 28, counted from the command beat
`default_nettype none

module i2c_master_bit_sequencer
  import i2cs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire in_beat_t in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_beat_t  out_data
);

`include "i2c_master_bit_sequencer_defines.svh"

  // sequencer state
  op_t        op_r, op_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_latch_r, ack_latch_nxt;
  logic       ack_sample_r, ack_sample_nxt;

  // result register
  logic       out_valid_r;
  out_beat_t  out_data_r, out_data_nxt;

  logic       in_fire;
  logic       cmd_ok;
  logic       is_idle;
  logic       take_cmd;
  op_t        op_eff;
  logic [4:0] p_eff;
  logic [7:0] shift_eff;
  logic       ack_latch_eff;
  logic [4:0] len_eff;
  logic [4:0] p_inc;
  logic       last_phase;
  logic [4:0] read_q;
  phase_split_t wsplit, rsplit;

  // the result register parts the two sides, so a waiting result blocks a new beat only while out_ready is low
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // codes five to seven count as no command
  assign cmd_ok   = (in_data.cmd >= 3'(OP_START)) && (in_data.cmd <= 3'(OP_READ));
  assign is_idle  = (op_r == OP_IDLE);
  assign take_cmd = is_idle && cmd_ok;

  // state as seen by this beat once a new command has been loaded
  always_comb begin
    op_eff        = op_r;
    p_eff         = phase_r;
    shift_eff     = shift_r;
    ack_latch_eff = ack_latch_r;
    if (take_cmd) begin
      op_eff = op_t'(in_data.cmd);
      p_eff  = 5'd0;
      if (op_t'(in_data.cmd) == OP_WRITE) begin
        shift_eff = in_data.tx_data;
      end else if (op_t'(in_data.cmd) == OP_READ) begin
        shift_eff     = 8'h00;
        ack_latch_eff = in_data.ack_to_send;
      end
    end
  end

  always_comb begin
    case (op_eff)
      OP_START: len_eff = LEN_START;
      OP_STOP:  len_eff = LEN_STOP;
      default:  len_eff = LEN_BYTE;
    endcase
  end

  assign p_inc      = p_eff + 5'd1;
  assign last_phase = (op_eff != OP_IDLE) && (p_inc >= len_eff);

  // bit slot decode: write slots start at phase 0, read slots after the release phase
  assign read_q = p_eff - 5'd1;
  assign wsplit = phase_split(p_eff);
  assign rsplit = phase_split(read_q);

  // next operation: advance to idle on the last phase of a command
  always_comb begin
    op_nxt = op_eff;
    if (last_phase) begin
      op_nxt = OP_IDLE;
    end
  end

  // line drives, shift register and result fields
  always_comb begin
    phase_nxt      = last_phase ? 5'd0 : p_inc;
    shift_nxt      = shift_eff;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_latch_nxt  = ack_latch_eff;
    ack_sample_nxt = ack_sample_r;

    case (op_eff)
      OP_IDLE: begin
        phase_nxt = phase_r;
      end
      OP_START: begin
        case (p_eff[1:0])
          2'd0:    sda_nxt = 1'b1;
          2'd1:    scl_nxt = 1'b1;
          2'd2:    sda_nxt = 1'b0;
          default: scl_nxt = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (p_eff[1:0])
          2'd0:    sda_nxt = 1'b0;
          2'd1:    scl_nxt = 1'b1;
          default: sda_nxt = 1'b1;
        endcase
      end
      OP_WRITE: begin
        if (p_eff < PH_ACK_SDA) begin
          case (wsplit.sub)
            SUB_SETUP: sda_nxt = shift_eff[3'd7 - wsplit.bit_idx];
            SUB_HIGH:  scl_nxt = 1'b1;
            default:   scl_nxt = 1'b0;
          endcase
        end else if (p_eff == PH_ACK_SDA) begin
          sda_nxt = 1'b1;
        end else if (p_eff == PH_ACK_SCL) begin
          scl_nxt = 1'b1;
        end else if (p_eff == PH_ACK_SMP) begin
          ack_sample_nxt = in_data.sda_in;
        end else begin
          scl_nxt = 1'b0;
        end
      end
      default: begin
        // read byte
        if (p_eff == 5'd0) begin
          sda_nxt = 1'b1;
        end else if (p_eff <= PH_ACK_SDA) begin
          case (rsplit.sub)
            SUB_SETUP: scl_nxt = 1'b1;
            SUB_HIGH:  shift_nxt = {shift_eff[6:0], in_data.sda_in};
            default:   scl_nxt = 1'b0;
          endcase
        end else if (p_eff == PH_RACK_SDA) begin
          sda_nxt = ack_latch_eff;
        end else if (p_eff == PH_RACK_SCL) begin
          scl_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b0;
        end
      end
    endcase

    out_data_nxt.scl_level = scl_nxt;
    out_data_nxt.sda_level = sda_nxt;
    out_data_nxt.busy_res  = (op_nxt != OP_IDLE);
    out_data_nxt.done_res  = last_phase;
    out_data_nxt.rx_data   = (last_phase && op_eff == OP_READ) ? shift_nxt : 8'h00;
    // ack is taken from the stored sample, the ack phase precedes the last one
    out_data_nxt.ack_seen  = last_phase && (op_eff == OP_WRITE) && ack_sample_r;
    out_data_nxt.rejected  = !is_idle && cmd_ok;
  end

  // state advances only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_IDLE;
      phase_r      <= 5'd0;
      shift_r      <= 8'h00;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_latch_r  <= 1'b0;
      ack_sample_r <= 1'b0;
    end else if (in_fire) begin
      op_r         <= op_nxt;
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_latch_r  <= ack_latch_nxt;
      ack_sample_r <= ack_sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  `I2CS_ASSERT(a_phase_in_range, phase_r < LEN_BYTE, "phase count beyond longest command")
  `I2CS_ASSERT_ALWAYS(a_idle_phase_zero, (op_r == OP_IDLE) |-> (phase_r == 5'd0), "idle with phase left over")
  `I2CS_ASSERT(a_done_not_busy, (out_valid_r && out_data_r.done_res) |-> !out_data_r.busy_res, "done beat still busy")
  `I2CS_ASSERT(a_data_only_on_done, (out_valid_r && !out_data_r.done_res) |-> (out_data_r.rx_data == 8'h00 && !out_data_r.ack_seen), "rx or ack without done")
  `I2CS_ASSERT(a_fire_gives_result, in_fire |=> out_valid_r, "accepted beat produced no result")

endmodule

`default_nettype wire

// ===== dv/tb_i2c_master_bit_sequencer.sv =====
// self-checking testbench for the i2c master bit sequencer with a line-phase predictor
module tb_i2c_master_bit_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cs_pkg::*;

  // run shape
  localparam int RANDOM_BEATS = 740;   // rough size of the random part
  localparam int TAIL_BEATS   = 120;   // last beats run with no idling on either side
  localparam int HOLD_AT      = 250;   // sent beats before the long receiver hold-off
  localparam int HOLD_CYCLES  = 150;
  localparam int PAUSE_AT     = 520;   // sender waits for every expected result here
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  i2c_master_bit_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // stimulus and expectations
  in_beat_t  line_beats[$];        // every input beat, in order
  out_beat_t expected_lines[$];    // predicted result beats not yet seen
  int        next_idx = 0;         // index of the beat on offer (or next to offer)
  logic      in_acc = 1'b0;        // an input beat was taken at the last rising edge

  // bookkeeping
  int fail_count = 0;
  int checked_count = 0;
  int done_count = 0;
  int reject_count = 0;
  int cycle_count = 0;
  int cmd_counts[5];

  // predictor copy of the line sequencer state
  op_t        cur_op;
  logic [4:0] phase_no;
  logic [7:0] shift_reg;
  logic       scl_q;
  logic       sda_q;
  logic       ack_to_drive;
  logic       slave_ack;

  // ---------------------------------------------------------------------------
  // predictor: one line phase per accepted beat
  // ---------------------------------------------------------------------------
  task automatic line_phase_step(input in_beat_t b, output out_beat_t r);
    logic       cmd_ok;
    int         p;
    int         slot;
    int         sub;
    int         len;
    op_t        op;
    cmd_ok = (b.cmd >= OP_START) && (b.cmd <= OP_READ);
    r = '0;

    // a command is only taken from idle; while busy it is flagged and dropped
    if (cur_op == OP_IDLE) begin
      if (cmd_ok) begin
        cur_op   = op_t'(b.cmd);
        phase_no = '0;
        if (cur_op == OP_WRITE) begin
          shift_reg = b.tx_data;
        end else if (cur_op == OP_READ) begin
          shift_reg    = '0;
          ack_to_drive = b.ack_to_send;
        end
      end
    end else if (cmd_ok) begin
      r.rejected = 1'b1;
    end

    if (cur_op != OP_IDLE) begin
      p  = phase_no;
      op = cur_op;
      case (op)
        OP_START: begin
          case (p)
            0: sda_q = 1'b1;
            1: scl_q = 1'b1;
            2: sda_q = 1'b0;
            default: scl_q = 1'b0;
          endcase
        end
        OP_STOP: begin
          case (p)
            0: sda_q = 1'b0;
            1: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
        end
        OP_WRITE: begin
          if (p < 24) begin
            slot = p / 3;
            sub  = p % 3;
            if (sub == SUB_SETUP) sda_q = shift_reg[7 - slot];
            else if (sub == SUB_HIGH) scl_q = 1'b1;
            else scl_q = 1'b0;
          end else if (p == PH_ACK_SDA) begin
            sda_q = 1'b1;
          end else if (p == PH_ACK_SCL) begin
            scl_q = 1'b1;
          end else if (p == PH_ACK_SMP) begin
            slave_ack = b.sda_in;
          end else begin
            scl_q = 1'b0;
          end
        end
        default: begin
          if (p == 0) begin
            sda_q = 1'b1;
          end else if (p <= 24) begin
            sub = (p - 1) % 3;
            if (sub == SUB_SETUP) scl_q = 1'b1;
            else if (sub == SUB_HIGH) shift_reg = {shift_reg[6:0], b.sda_in};
            else scl_q = 1'b0;
          end else if (p == PH_RACK_SDA) begin
            sda_q = ack_to_drive;
          end else if (p == PH_RACK_SCL) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
        end
      endcase

      len = (op == OP_START) ? LEN_START : (op == OP_STOP) ? LEN_STOP : LEN_BYTE;
      if (p + 1 >= len) begin
        r.done_res = 1'b1;
        if (op == OP_WRITE) r.ack_seen = slave_ack;
        if (op == OP_READ) r.rx_data = shift_reg;
        cur_op   = OP_IDLE;
        phase_no = '0;
      end else begin
        phase_no = phase_no + 5'd1;
      end
    end

    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (cur_op != OP_IDLE);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // idle ticks, now and then carrying an unknown command code
  task automatic queue_idle(input int n);
    in_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = in_beat_t'($urandom);
      b.cmd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : 3'(OP_IDLE);
      line_beats.push_back(b);
    end
  endtask

  // one whole command from its command beat to its last phase;
  // clash_phase puts a real command on that phase, noise_pct scatters stray codes
  task automatic queue_command(input op_t op, input logic [7:0] tx, input logic ack,
                               input logic [27:0] sda_bits, input int noise_pct,
                               input int clash_phase);
    in_beat_t b;
    int       len;
    len = (op == OP_START) ? LEN_START : (op == OP_STOP) ? LEN_STOP : LEN_BYTE;
    cmd_counts[op]++;
    for (int k = 0; k < len; k++) begin
      b = in_beat_t'($urandom);
      b.sda_in = sda_bits[k];
      if (k == 0) begin
        b.cmd         = op;
        b.tx_data     = tx;
        b.ack_to_send = ack;
      end else if (k == clash_phase) begin
        b.cmd = 3'($urandom_range(OP_START, OP_READ));
      end else if ($urandom_range(0, 99) < noise_pct) begin
        b.cmd = 3'($urandom_range(1, 7));
      end else begin
        b.cmd = OP_IDLE;
      end
      line_beats.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: input beats change on the falling edge
  // ---------------------------------------------------------------------------
  int in_gap_left = 0;

  always @(negedge clk) begin
    logic nv;
    logic in_tail;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_acc) next_idx = next_idx + 1;
      in_tail = (line_beats.size() - next_idx) <= TAIL_BEATS;
      nv = 1'b0;
      if (in_valid && !in_acc) begin
        // beat still on offer: hold it unchanged
        nv = 1'b1;
      end else if (in_acc && !in_tail && $urandom_range(0, 5) == 0) begin
        // start an idle burst, this cycle being its first
        in_gap_left = $urandom_range(1, 16) - 1;
      end else if (in_gap_left > 0) begin
        in_gap_left = in_gap_left - 1;
      end else if (next_idx == PAUSE_AT && expected_lines.size() != 0) begin
        // sender pause: let every expected result come back first
        nv = 1'b0;
      end else if (next_idx < line_beats.size()) begin
        nv = 1'b1;
        in_data <= line_beats[next_idx];
      end
      in_valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready changes on the falling edge
  // ---------------------------------------------------------------------------
  int   out_stall_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    logic out_tail;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_tail = (line_beats.size() - next_idx) <= TAIL_BEATS;
      if (!hold_done && next_idx >= HOLD_AT) begin
        // long hold-off while the sender keeps offering, so the block backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left = out_stall_left - 1;
        out_ready <= 1'b0;
      end else if (!out_tail && $urandom_range(0, 7) == 0) begin
        out_stall_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t exp_beat;
    out_beat_t got;
    logic      bad;
    if (!rst_n) begin
      in_acc       <= 1'b0;
      cur_op       = OP_IDLE;
      phase_no     = '0;
      shift_reg    = '0;
      scl_q        = 1'b1;
      sda_q        = 1'b1;
      ack_to_drive = 1'b0;
      slave_ack    = 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        line_phase_step(in_data, exp_beat);
        if (exp_beat.done_res) done_count++;
        if (exp_beat.rejected) reject_count++;
        expected_lines.push_back(exp_beat);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_lines.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result beat with nothing expected: %p", $realtime, got);
        end else begin
          exp_beat = expected_lines.pop_front();
          checked_count++;
          bad = (got.scl_level !== exp_beat.scl_level) ||
                (got.sda_level !== exp_beat.sda_level) ||
                (got.busy_res  !== exp_beat.busy_res)  ||
                (got.done_res  !== exp_beat.done_res)  ||
                (got.rx_data   !== exp_beat.rx_data)   ||
                (got.ack_seen  !== exp_beat.ack_seen)  ||
                (got.rejected  !== exp_beat.rejected);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] beat %0d mismatch: expected %p, got %p",
                       $realtime, checked_count - 1, exp_beat, got);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_lines.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    int pick;
    int len;
    op_t op;

    // directed: unknown codes while idle, then each command with its corner cases
    queue_idle(1);
    line_beats.push_back('{cmd: 3'd5, tx_data: 8'h00, ack_to_send: 1'b0, sda_in: 1'b0});
    line_beats.push_back('{cmd: 3'd6, tx_data: 8'hFF, ack_to_send: 1'b1, sda_in: 1'b1});
    line_beats.push_back('{cmd: 3'd7, tx_data: 8'hA5, ack_to_send: 1'b1, sda_in: 1'b0});
    queue_command(OP_START, 8'h00, 1'b0, 28'h0, 0, -1);
    // write all ones, slave nacks, a command clashes mid-byte
    queue_command(OP_WRITE, 8'hFF, 1'b0, 28'hFFFFFFF, 0, 5);
    // write all zeros, slave acks, stray codes scattered over the byte
    queue_command(OP_WRITE, 8'h00, 1'b1, 28'h0, 30, -1);
    // read all ones and nack, a command clashes on the last phase
    queue_command(OP_READ, 8'h00, 1'b1, 28'hFFFFFFF, 0, LEN_BYTE - 1);
    // read all zeros and ack, issued right after the previous done
    queue_command(OP_READ, 8'hFF, 1'b0, 28'h0, 0, -1);
    queue_command(OP_READ, 8'h00, 1'b0, 28'h5A5A5A5, 0, 1);
    queue_command(OP_STOP, 8'h00, 1'b0, 28'h0, 0, LEN_STOP - 1);
    queue_command(OP_START, 8'h00, 1'b0, 28'h0, 0, 1);
    queue_command(OP_STOP, 8'h00, 1'b0, 28'h0, 0, -1);
    queue_idle(2);

    // random: mostly well-formed transfers with random content, some noise
    target = line_beats.size() + RANDOM_BEATS;
    while (line_beats.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_idle($urandom_range(1, 4));
      end else begin
        op = (pick < 25) ? OP_START : (pick < 40) ? OP_STOP : (pick < 70) ? OP_WRITE : OP_READ;
        len = (op == OP_START) ? LEN_START : (op == OP_STOP) ? LEN_STOP : LEN_BYTE;
        queue_command(op, 8'($urandom), 1'($urandom), 28'($urandom), 6,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : -1);
      end
    end

    // synchronous reset, released away from the rising edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (next_idx < line_beats.size()) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d line beats: %0d starts, %0d stops, %0d writes, %0d reads queued",
             line_beats.size(), cmd_counts[OP_START], cmd_counts[OP_STOP],
             cmd_counts[OP_WRITE], cmd_counts[OP_READ]);
    $display("checked %0d result beats, %0d command completions, %0d busy rejections, %0d bad",
             checked_count, done_count, reject_count, fail_count);
    if (fail_count == 0 && expected_lines.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
